/* src/lsh_pkg.sv */
// Shared types, constants and mixing helpers of the lookup2 string hash unit.
package lsh_pkg;

  localparam logic [31:0] GOLDEN = 32'h9e3779b9;
  localparam int BlockBytes = 12;
  localparam int MixSteps = 9;

  localparam logic [1:0] ROW_A = 2'd0;
  localparam logic [1:0] ROW_B = 2'd1;
  localparam logic [1:0] ROW_C = 2'd2;

  typedef struct packed {
    logic        first;
    logic        blk;
    logic        fin;
    logic [31:0] seed;
    logic [31:0] wa;
    logic [31:0] wb;
    logic [31:0] wc;
    logic [31:0] len;
  } job_t;

  function automatic logic [4:0] mix_shift(input logic [3:0] step);
    logic [4:0] sh;
    case (step)
      4'd0: sh = 5'd13;
      4'd1: sh = 5'd8;
      4'd2: sh = 5'd13;
      4'd3: sh = 5'd12;
      4'd4: sh = 5'd16;
      4'd5: sh = 5'd5;
      4'd6: sh = 5'd3;
      4'd7: sh = 5'd10;
      4'd8: sh = 5'd15;
      default: sh = 5'd0;
    endcase
    return sh;
  endfunction

  function automatic logic [1:0] mix_row(input logic [3:0] step);
    logic [1:0] row;
    case (step)
      4'd0, 4'd3, 4'd6: row = ROW_A;
      4'd1, 4'd4, 4'd7: row = ROW_B;
      default: row = ROW_C;
    endcase
    return row;
  endfunction

endpackage

/* src/lookup2_string_hash_unit.sv */
// Top level of the streaming lookup2 32-bit string hash unit.
// Usage:
//   Input queue side: drive data_byte_i, last_i, no_byte_i with push; an item is
//   taken when push is high and full is low. One key byte per item; last_i marks
//   the end of a key; no_byte_i with last_i hashes an empty key.
//   Result queue side: while empty is low, hash_value_o holds the oldest hash;
//   pulse pop to take it.
//   Seed: cfg_we_i writes cfg_data_i as the seed of the third mixing word; it
//   applies from the next key that has received no byte yet.
// Timing:
//   Bytes are taken one per cycle while full is low. Each 12-byte block and
//   each key end is a job for the mixer (one job when the final byte completes
//   a block; it is mixed, gets the length added and is mixed again). The mixer
//   runs one of its nine steps per cycle unless it stalls on a held result.
//   Long keys run at one byte per cycle; the rate of very short keys is set
//   by the mixer, which takes a new job only once the last one is done.
// Reset clears the queues, the byte counters and the seed to zero.
// If the receiver stalls, the result register holds, the mixer waits on its
// final step, the job queue fills and full rises.
module lookup2_string_hash_unit #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic        no_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] hash_value_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i
);

  lsh_pkg::job_t job_in, job_out;
  logic          job_push, job_pop, job_empty, acc;

  assign acc = push && !full;

  lsh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .no_byte_i   (no_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .job_o       (job_in),
    .job_push_o  (job_push)
  );

  lsh_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  lsh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_out),
    .job_valid_i  (!job_empty),
    .job_pop_o    (job_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .hash_value_o (hash_value_o)
  );

endmodule

/* src/lsh_front.sv */
// Front end: takes key bytes, assembles 12-byte blocks and tails, issues mixing jobs.
module lsh_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_i,
  input  logic                no_byte_i,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_data_i,
  output lsh_pkg::job_t       job_o,
  output logic                job_push_o
);

  localparam int BufBytes = lsh_pkg::BlockBytes - 1;

  logic [7:0]  blk_byte_q [BufBytes];
  logic [3:0]  fill_q, fill_d;
  logic [31:0] len_q, len_d;
  logic [31:0] seed_q;
  logic [31:0] init_value_q;
  logic        first_q, first_d;

  logic        has_byte;
  logic        full_blk;
  logic [3:0]  n_eff;
  logic [31:0] len_next;
  logic [31:0] seed_eff;
  logic [7:0]  m [lsh_pkg::BlockBytes];
  logic [7:0]  t [lsh_pkg::BlockBytes];
  logic [31:0] tail_c;

  assign has_byte = !no_byte_i;
  assign n_eff    = fill_q + {3'd0, has_byte};
  assign full_blk = has_byte && (fill_q == 4'(lsh_pkg::BlockBytes - 1));
  assign len_next = len_q + {31'd0, has_byte};
  assign seed_eff = (len_q == '0) ? init_value_q : seed_q;

  always_comb begin
    for (int i = 0; i < lsh_pkg::BlockBytes; i++) begin
      if (i == lsh_pkg::BlockBytes - 1) begin
        m[i] = data_byte_i;
      end else begin
        m[i] = (has_byte && fill_q == 4'(i)) ? data_byte_i : blk_byte_q[i];
      end
      t[i] = (4'(i) < n_eff) ? m[i] : 8'd0;
    end
  end

  assign tail_c = {t[10], t[9], t[8], 8'd0} + len_next;

  always_comb begin
    job_o.first = first_q;
    job_o.blk   = full_blk;
    job_o.fin   = last_i;
    job_o.seed  = seed_eff;
    job_o.len   = len_next;
    if (full_blk) begin
      job_o.wa = {m[3], m[2], m[1], m[0]};
      job_o.wb = {m[7], m[6], m[5], m[4]};
      job_o.wc = {m[11], m[10], m[9], m[8]};
    end else begin
      job_o.wa = {t[3], t[2], t[1], t[0]};
      job_o.wb = {t[7], t[6], t[5], t[4]};
      job_o.wc = tail_c;
    end
  end

  assign job_push_o = acc_i && (full_blk || last_i);

  always_comb begin
    fill_d  = fill_q;
    len_d   = len_q;
    first_d = first_q;
    if (acc_i) begin
      fill_d = full_blk ? 4'd0 : n_eff;
      len_d  = len_next;
      if (full_blk) begin
        first_d = 1'b0;
      end
      if (last_i) begin
        fill_d  = 4'd0;
        len_d   = '0;
        first_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= 4'd0;
      len_q        <= '0;
      first_q      <= 1'b1;
      init_value_q <= '0;
    end else begin
      fill_q  <= fill_d;
      len_q   <= len_d;
      first_q <= first_d;
      if (cfg_we_i) begin
        init_value_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && len_q == '0) begin
      seed_q <= init_value_q;
    end
    for (int i = 0; i < BufBytes; i++) begin
      if (acc_i && has_byte && fill_q == 4'(i)) begin
        blk_byte_q[i] <= data_byte_i;
      end
    end
  end

endmodule

/* src/lsh_queue.sv */
// Short job queue between the front end and the mixing back end.
module lsh_queue #(
  parameter int Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lsh_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output lsh_pkg::job_t data_o,
  output logic          empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  lsh_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

/* src/lsh_back.sv */
// Back end: one lookup2 mix step per cycle unless stalled; holds the result register.
module lsh_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lsh_pkg::job_t job_i,
  input  logic          job_valid_i,
  output logic          job_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [31:0]   hash_value_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MIX  = 2'd1;
  localparam logic [1:0] S_ADD  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic        cur_fin_q, cur_fin_d;
  logic        fin_pend_q, fin_pend_d;
  logic [31:0] fc_q, fc_d;
  logic [31:0] a_q, a_d, b_q, b_d, c_q, c_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_q, out_d;

  logic [4:0]  sh;
  logic [1:0]  row;
  logic [31:0] na, nb, nc;
  logic        last_step, out_free, emit, stall;

  assign sh        = lsh_pkg::mix_shift(step_q);
  assign row       = lsh_pkg::mix_row(step_q);
  assign na        = (a_q - b_q - c_q) ^ (c_q >> sh);
  assign nb        = (b_q - c_q - a_q) ^ (a_q << sh);
  assign nc        = (c_q - a_q - b_q) ^ (b_q >> sh);
  assign last_step = (step_q == 4'(lsh_pkg::MixSteps - 1));
  assign out_free  = !out_valid_q || pop_i;
  assign emit      = (state_q == S_MIX) && last_step && cur_fin_q && out_free;
  assign stall     = (state_q == S_MIX) && last_step && cur_fin_q && !out_free;
  assign job_pop_o = (state_q == S_IDLE) && job_valid_i;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cur_fin_d   = cur_fin_q;
    fin_pend_d  = fin_pend_q;
    fc_d        = fc_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    out_valid_d = out_valid_q && !pop_i;
    out_d       = out_q;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          a_d        = (job_i.first ? lsh_pkg::GOLDEN : a_q) + job_i.wa;
          b_d        = (job_i.first ? lsh_pkg::GOLDEN : b_q) + job_i.wb;
          c_d        = (job_i.first ? job_i.seed : c_q) + job_i.wc;
          cur_fin_d  = job_i.fin && !job_i.blk;
          fin_pend_d = job_i.fin && job_i.blk;
          fc_d       = job_i.len;
          step_d     = 4'd0;
          state_d    = S_MIX;
        end
      end
      S_MIX: begin
        if (!stall) begin
          case (row)
            lsh_pkg::ROW_A: a_d = na;
            lsh_pkg::ROW_B: b_d = nb;
            default:        c_d = nc;
          endcase
          if (last_step) begin
            if (cur_fin_q) begin
              out_valid_d = 1'b1;
              out_d       = nc;
              state_d     = S_IDLE;
            end else if (fin_pend_q) begin
              state_d = S_ADD;
            end else begin
              state_d = S_IDLE;
            end
          end else begin
            step_d = step_q + 4'd1;
          end
        end
      end
      S_ADD: begin
        c_d        = c_q + fc_q;
        cur_fin_d  = 1'b1;
        fin_pend_d = 1'b0;
        step_d     = 4'd0;
        state_d    = S_MIX;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= 4'd0;
      cur_fin_q   <= 1'b0;
      fin_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cur_fin_q   <= cur_fin_d;
      fin_pend_q  <= fin_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fc_q  <= fc_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    out_q <= out_d;
  end

  assign empty_o      = !out_valid_q;
  assign hash_value_o = out_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= 4'(lsh_pkg::MixSteps - 1))
    else $error("mix step counter out of range");

  a_fin_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cur_fin_q && fin_pend_q))
    else $error("final phase both current and pending");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |=> out_valid_q && $stable(out_q))
    else $error("waiting result lost or changed");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(c_q) && $stable(step_q) && (state_q == S_MIX))
    else $error("mixer advanced while result register blocked");

endmodule
